// ----- src/edmt_pkg.sv -----
// ----------------------------------------------------------------------------
// edmt_pkg: egg drop minimum trials, shared definitions
// Field widths, parameter defaults, sequencer step and condition codes, and
// the microcode program that drives the datapath.
// ----------------------------------------------------------------------------
package edmt_pkg;

  localparam int VAL_W          = 10;   // table entry and result width
  localparam int EGG_IN_W       = 5;
  localparam int FLR_IN_W       = 10;
  localparam int MAX_EGGS_DEF   = 16;
  localparam int MAX_FLOORS_DEF = 1023;

  localparam int STEP_W = 4;
  localparam int COND_W = 3;

  // sequencer steps
  localparam logic [STEP_W-1:0] S_IDLE  = 4'd0;
  localparam logic [STEP_W-1:0] S_ROW   = 4'd1;
  localparam logic [STEP_W-1:0] S_COL   = 4'd2;
  localparam logic [STEP_W-1:0] S_LOOP  = 4'd3;
  localparam logic [STEP_W-1:0] S_DRAIN = 4'd4;
  localparam logic [STEP_W-1:0] S_WB    = 4'd5;
  localparam logic [STEP_W-1:0] S_ROWNX = 4'd6;
  localparam logic [STEP_W-1:0] S_FIN   = 4'd7;
  localparam logic [STEP_W-1:0] S_GET   = 4'd8;
  localparam logic [STEP_W-1:0] S_OUT   = 4'd9;

  // jump conditions
  localparam logic [COND_W-1:0] C_ALWAYS   = 3'd0;
  localparam logic [COND_W-1:0] C_NO_IN    = 3'd1;
  localparam logic [COND_W-1:0] C_ROW_DONE = 3'd2;
  localparam logic [COND_W-1:0] C_COL_DONE = 3'd3;
  localparam logic [COND_W-1:0] C_X_MORE   = 3'd4;
  localparam logic [COND_W-1:0] C_OUT_BUSY = 3'd5;

  typedef struct packed {
    logic [COND_W-1:0] cond;
    logic [STEP_W-1:0] jmp;      // taken when cond holds
    logic [STEP_W-1:0] nxt;      // taken otherwise
    logic              take;     // accept a request
    logic              set_j;
    logic              start_x;
    logic              issue;    // read both operands for current x
    logic              wr;       // write best into the table
    logic              inc_i;
    logic              ans;      // read the answer entry
    logic              latch;
    logic              emit;
  } cw_t;

  function automatic cw_t ucode(input logic [STEP_W-1:0] step);
    cw_t cw;
    cw = '0;
    cw.cond = C_ALWAYS;
    cw.jmp  = S_IDLE;
    cw.nxt  = S_IDLE;
    case (step)
      S_IDLE: begin
        cw.take = 1'b1; cw.cond = C_NO_IN; cw.jmp = S_IDLE; cw.nxt = S_ROW;
      end
      S_ROW: begin
        cw.set_j = 1'b1; cw.cond = C_ROW_DONE; cw.jmp = S_FIN; cw.nxt = S_COL;
      end
      S_COL: begin
        cw.start_x = 1'b1; cw.cond = C_COL_DONE; cw.jmp = S_ROWNX; cw.nxt = S_LOOP;
      end
      S_LOOP: begin
        cw.issue = 1'b1; cw.cond = C_X_MORE; cw.jmp = S_LOOP; cw.nxt = S_DRAIN;
      end
      S_DRAIN: begin
        cw.jmp = S_WB;
      end
      S_WB: begin
        cw.wr = 1'b1; cw.jmp = S_COL;
      end
      S_ROWNX: begin
        cw.inc_i = 1'b1; cw.jmp = S_ROW;
      end
      S_FIN: begin
        cw.ans = 1'b1; cw.jmp = S_GET;
      end
      S_GET: begin
        cw.latch = 1'b1; cw.jmp = S_OUT;
      end
      S_OUT: begin
        cw.emit = 1'b1; cw.cond = C_OUT_BUSY; cw.jmp = S_OUT; cw.nxt = S_IDLE;
      end
      default: begin
        cw.jmp = S_IDLE;
      end
    endcase
    return cw;
  endfunction

endpackage

// ----- src/edmt_ram.sv -----
// ----------------------------------------------------------------------------
// edmt_ram: generic RAM, one write port, two registered read ports
// Contents are undefined until written.
// ----------------------------------------------------------------------------
module edmt_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_a_addr,
  output logic [WIDTH-1:0] rd_a_data,
  input  logic [AW-1:0]    rd_b_addr,
  output logic [WIDTH-1:0] rd_b_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a_data <= mem[rd_a_addr];
    rd_b_data <= mem[rd_b_addr];
  end

endmodule

// ----- src/egg_drop_min_trials_unit.sv -----
// ----------------------------------------------------------------------------
// egg_drop_min_trials_unit: worst-case minimum drops for E eggs, F floors
// Dynamic programming over a scratch table, driven by a microcoded sequencer.
// ----------------------------------------------------------------------------
//  channel | dir | tdata fields (low bit up)              | request
//  in_     | in  | egg_count[4:0], floor_count[14:5], pad  | one problem
//  out_    | out | min_trials[9:0], pad                    | one answer
//
//  One drop floor x is evaluated per cycle, set by the dual-read table RAM.
//  Reset clears the sequencer, pipeline valid and result valid only; the table
//  is never cleared, since row one and columns zero and one are generated.
//  A waiting result sits in the output register; the next request is taken
//  meanwhile and only its own result waits for the register to free up.
module egg_drop_min_trials_unit #(
  parameter int MAX_EGGS   = edmt_pkg::MAX_EGGS_DEF,
  parameter int MAX_FLOORS = edmt_pkg::MAX_FLOORS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // egg_count[4:0], floor_count[14:5], zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // min_trials[9:0], zero
);

  localparam int VW    = edmt_pkg::VAL_W;
  localparam int EW    = $clog2(MAX_EGGS + 1);
  localparam int FW    = $clog2(MAX_FLOORS + 1);
  localparam int AW    = EW + FW;
  localparam int DEPTH = (MAX_EGGS + 1) << FW;

  edmt_pkg::cw_t cw;

  logic [edmt_pkg::STEP_W-1:0] step_r, step_nxt;
  logic [EW-1:0]  eggs_r;
  logic [FW-1:0]  floors_r;
  logic [EW:0]    i_r;
  logic [FW:0]    j_r;
  logic [FW:0]    x_r;
  logic [VW-1:0]  best_r;
  logic           pv_r;
  logic           brk_fix_r, srv_fix_r;
  logic [VW-1:0]  brk_val_r, srv_val_r;
  logic           ans_fix_r;
  logic [VW-1:0]  ans_val_r;
  logic [VW-1:0]  ans_r;
  logic           out_valid_r;
  logic [VW-1:0]  out_data_r;

  logic           in_fire;
  logic           jump;
  logic           out_busy;
  logic [6:0]     egg_in;
  logic [16:0]    flr_in;
  logic [EW-1:0]  egg_clamp;
  logic [FW-1:0]  flr_clamp;
  logic [EW:0]    im1;
  logic [FW:0]    xm1;
  logic [FW:0]    jmx;
  logic [AW-1:0]  rd_a_addr, rd_b_addr, wr_addr;
  logic [VW-1:0]  rd_a_data, rd_b_data;
  logic [VW-1:0]  brk, srv, worst;
  logic [VW:0]    cand;

  assign cw        = edmt_pkg::ucode(step_r);
  assign in_tready = cw.take;
  assign in_fire   = in_tvalid && in_tready;
  assign out_busy  = out_valid_r && !out_tready;

  // request clamping: zero eggs means one, then saturate to the table size
  assign egg_in = 7'(in_tdata[4:0]);
  assign flr_in = 17'(in_tdata[14:5]);
  always_comb begin
    if (egg_in == 7'd0) begin
      egg_clamp = EW'(1);
    end else if (egg_in > 7'(MAX_EGGS)) begin
      egg_clamp = EW'(MAX_EGGS);
    end else begin
      egg_clamp = EW'(egg_in);
    end
    if (flr_in > 17'(MAX_FLOORS)) begin
      flr_clamp = FW'(MAX_FLOORS);
    end else begin
      flr_clamp = FW'(flr_in);
    end
  end

  always_comb begin
    case (cw.cond)
      edmt_pkg::C_ALWAYS:   jump = 1'b1;
      edmt_pkg::C_NO_IN:    jump = !in_tvalid;
      edmt_pkg::C_ROW_DONE: jump = i_r > (EW+1)'(eggs_r);
      edmt_pkg::C_COL_DONE: jump = j_r > (FW+1)'(floors_r);
      edmt_pkg::C_X_MORE:   jump = x_r != j_r;
      edmt_pkg::C_OUT_BUSY: jump = out_busy;
      default:              jump = 1'b1;
    endcase
    step_nxt = jump ? cw.jmp : cw.nxt;
  end

  // operand addresses: break case T[i-1][x-1], survive case T[i][j-x]
  assign im1 = i_r - (EW+1)'(1);
  assign xm1 = x_r - (FW+1)'(1);
  assign jmx = j_r - x_r;

  always_comb begin
    if (cw.ans) begin
      rd_a_addr = {eggs_r, floors_r};
    end else begin
      rd_a_addr = {im1[EW-1:0], xm1[FW-1:0]};
    end
  end
  assign rd_b_addr = {i_r[EW-1:0], jmx[FW-1:0]};
  assign wr_addr   = {i_r[EW-1:0], j_r[FW-1:0]};

  edmt_ram #(
    .WIDTH (VW),
    .DEPTH (DEPTH)
  ) u_table (
    .clk       (clk),
    .wr_en     (cw.wr),
    .wr_addr   (wr_addr),
    .wr_data   (best_r),
    .rd_a_addr (rd_a_addr),
    .rd_a_data (rd_a_data),
    .rd_b_addr (rd_b_addr),
    .rd_b_data (rd_b_data)
  );

  assign brk   = brk_fix_r ? brk_val_r : rd_a_data;
  assign srv   = srv_fix_r ? srv_val_r : rd_b_data;
  assign worst = (brk > srv) ? brk : srv;
  assign cand  = (VW+1)'(worst) + (VW+1)'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= edmt_pkg::S_IDLE;
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      pv_r   <= cw.issue;
      if (cw.emit && !out_busy) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      eggs_r   <= egg_clamp;
      floors_r <= flr_clamp;
      i_r      <= (EW+1)'(2);
    end
    if (cw.inc_i) begin
      i_r <= i_r + (EW+1)'(1);
    end
    if (cw.set_j) begin
      j_r <= (FW+1)'(2);
    end
    if (cw.wr) begin
      j_r <= j_r + (FW+1)'(1);
    end
    if (cw.start_x) begin
      x_r    <= (FW+1)'(1);
      best_r <= VW'(j_r);
    end
    if (cw.issue) begin
      x_r <= x_r + (FW+1)'(1);
      // row one holds j, columns zero and one hold their index
      brk_fix_r <= (i_r == (EW+1)'(2)) || (x_r <= (FW+1)'(2));
      brk_val_r <= VW'(xm1);
      srv_fix_r <= jmx <= (FW+1)'(1);
      srv_val_r <= VW'(jmx);
    end
    if (pv_r && (cand < (VW+1)'(best_r))) begin
      best_r <= cand[VW-1:0];
    end
    if (cw.ans) begin
      ans_fix_r <= (eggs_r == EW'(1)) || (floors_r <= FW'(1));
      ans_val_r <= VW'(floors_r);
    end
    if (cw.latch) begin
      ans_r <= ans_fix_r ? ans_val_r : rd_a_data;
    end
    if (cw.emit && !out_busy) begin
      out_data_r <= ans_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = 16'(out_data_r);

  a_best_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (step_r == edmt_pkg::S_WB) |-> (best_r <= VW'(j_r)))
    else $error("best exceeds floor count");

  a_wr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cw.wr |-> ((i_r <= (EW+1)'(eggs_r)) && (j_r <= (FW+1)'(floors_r))))
    else $error("table write outside requested range");

  a_issue_x: assert property (@(posedge clk) disable iff (!rst_n)
    cw.issue |-> ((x_r != '0) && (x_r <= j_r)))
    else $error("drop floor out of range");

  a_drain_order: assert property (@(posedge clk) disable iff (!rst_n)
    (step_r == edmt_pkg::S_DRAIN) |-> ($past(step_r) == edmt_pkg::S_LOOP))
    else $error("drain not preceded by loop");

  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(step_r) == edmt_pkg::S_OUT))
    else $error("result raised outside output step");

endmodule
